>>> hdl/bpc_pkg.sv
// Shared types and constants for the button press classifier.
// Used by bpc_lane, bpc_merge and button_press_classifier; depends on nothing.
`default_nettype none

package bpc_pkg;

	localparam int CFG_W = 16;

	// Configuration register indexes (byte address divided by four).
	localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [1:0] REG_MIN_PRESS  = 2'd1;
	localparam logic [1:0] REG_LONG_PRESS = 2'd2;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd5;
	localparam logic [CFG_W-1:0] MIN_PRESS_RST  = 16'd5;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd2000;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ticks;
		logic [CFG_W-1:0] min_press_ticks;
		logic [CFG_W-1:0] long_press_ticks;
	} cfg_t;

	// What one lane reports for the current tick.
	typedef struct packed {
		logic short_pulse;
		logic long_pulse;
		logic level;
	} lane_res_t;

endpackage

`default_nettype wire

>>> hdl/button_press_classifier.sv
// Top level of the button press classifier: configuration registers, one
// lane per button and the merge stage. Depends on bpc_pkg, bpc_lane, bpc_merge.
//
// Usage: each slave-side transaction is one millisecond tick carrying the raw
// active-low levels of the buttons. Every tick yields exactly one master-side
// transaction with the short-press pulses, long-press pulses and debounced
// levels of that tick. All lanes update in the cycle the tick is accepted and
// the merged result is registered, so a result appears in the cycle after its
// tick; a new tick can be accepted every cycle unless the receiver stalls. The
// input is ready whenever the output register is empty or being emptied in the
// same cycle; if the receiver stalls, one result is held and s_tready drops
// until it is taken. Thresholds are written through the APB port at 0x0
// (debounce), 0x4 (minimum press) and 0x8 (long press); the user must write
// them only while no tick is in flight; the block does not enforce it. After
// reset buttons read released, ages are zero, thresholds 5, 5 and 2000 ticks.
`default_nettype none

module button_press_classifier #(
	parameter int BUTTONS  = 4,
	parameter int AGE_BITS = 16
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// Tick input: raw_levels in bits BUTTONS-1:0.
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	input  wire  [((BUTTONS + 7) / 8) * 8 - 1:0]  s_tdata,
	// Result: short_pulses, then long_pulses, then settled_levels, from bit 0.
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	output logic [((3*BUTTONS + 7) / 8) * 8 - 1:0] m_tdata,
	// Configuration port.
	input  wire                                   psel,
	input  wire                                   penable,
	input  wire                                   pwrite,
	input  wire  [3:0]                            paddr,
	input  wire  [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);
	import bpc_pkg::*;

	localparam int OUT_W = ((3*BUTTONS + 7) / 8) * 8;

	cfg_t       cfg_q;
	lane_res_t  lane_res [BUTTONS];
	logic       tick;
	logic       space;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks   <= DEBOUNCE_RST;
			cfg_q.min_press_ticks  <= MIN_PRESS_RST;
			cfg_q.long_press_ticks <= LONG_PRESS_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_DEBOUNCE:   cfg_q.debounce_ticks   <= pwdata[CFG_W-1:0];
				REG_MIN_PRESS:  cfg_q.min_press_ticks  <= pwdata[CFG_W-1:0];
				REG_LONG_PRESS: cfg_q.long_press_ticks <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DEBOUNCE:   prdata = 32'(cfg_q.debounce_ticks);
			REG_MIN_PRESS:  prdata = 32'(cfg_q.min_press_ticks);
			REG_LONG_PRESS: prdata = 32'(cfg_q.long_press_ticks);
			default:        prdata = '0;
		endcase
	end

	assign s_tready = space;
	assign tick     = s_tvalid && space;

	for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
		bpc_lane #(
			.AGE_BITS (AGE_BITS)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.tick      (tick),
			.raw_level (s_tdata[b]),
			.cfg       (cfg_q),
			.res       (lane_res[b])
		);
	end

	bpc_merge #(
		.BUTTONS (BUTTONS),
		.OUT_W   (OUT_W)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (tick),
		.res      (lane_res),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.space    (space)
	);

endmodule

`default_nettype wire

>>> hdl/bpc_lane.sv
// One button lane: debounce, press timing and short/long press detection.
// Depends on bpc_pkg for the configuration and result types.
`default_nettype none

module bpc_lane #(
	parameter int AGE_BITS = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  tick,
	input  wire                  raw_level,
	input  bpc_pkg::cfg_t        cfg,
	output bpc_pkg::lane_res_t   res
);
	import bpc_pkg::*;

	localparam int CMP_W = (AGE_BITS > CFG_W) ? AGE_BITS : CFG_W;

	logic                prev_q;
	logic                settled_q;
	logic [AGE_BITS-1:0] change_age_q;
	logic [AGE_BITS-1:0] press_age_q;
	logic                seen_q;
	logic                long_done_q;

	logic [AGE_BITS-1:0] change_age_d;
	logic [AGE_BITS-1:0] press_age_d;
	logic                settled_d;
	logic                seen_d;
	logic                long_done_d;
	logic                short_pulse;
	logic                long_pulse;
	logic                settle;

	always_comb begin
		change_age_d = (change_age_q == '1) ? change_age_q : change_age_q + AGE_BITS'(1);
		press_age_d  = (press_age_q == '1) ? press_age_q : press_age_q + AGE_BITS'(1);
		if (raw_level != prev_q) begin
			change_age_d = '0;
		end

		settled_d   = settled_q;
		seen_d      = seen_q;
		long_done_d = long_done_q;
		short_pulse = 1'b0;
		long_pulse  = 1'b0;

		settle = (CMP_W'(change_age_d) >= CMP_W'(cfg.debounce_ticks)) &&
			(raw_level != settled_q);
		if (settle) begin
			settled_d = raw_level;
			if (!raw_level) begin
				seen_d      = 1'b1;
				press_age_d = '0;
				long_done_d = 1'b0;
			end else begin
				short_pulse = seen_q && !long_done_q &&
					(CMP_W'(press_age_d) >= CMP_W'(cfg.min_press_ticks));
				seen_d = 1'b0;
			end
		end

		if (!settled_d && seen_d && !long_done_d &&
			(CMP_W'(press_age_d) >= CMP_W'(cfg.long_press_ticks))) begin
			long_done_d = 1'b1;
			long_pulse  = 1'b1;
		end

		res.short_pulse = short_pulse;
		res.long_pulse  = long_pulse;
		res.level       = settled_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q       <= 1'b1;
			settled_q    <= 1'b1;
			change_age_q <= '0;
			press_age_q  <= '0;
			seen_q       <= 1'b0;
			long_done_q  <= 1'b0;
		end else if (tick) begin
			prev_q       <= raw_level;
			settled_q    <= settled_d;
			change_age_q <= change_age_d;
			press_age_q  <= press_age_d;
			seen_q       <= seen_d;
			long_done_q  <= long_done_d;
		end
	end

endmodule

`default_nettype wire

>>> hdl/bpc_merge.sv
// Merge stage: gathers the lane results into one output word and holds it
// in the output register until the receiver takes it. Depends on bpc_pkg.
`default_nettype none

module bpc_merge #(
	parameter int BUTTONS = 4,
	parameter int OUT_W   = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   load,
	input  bpc_pkg::lane_res_t    res [BUTTONS],
	output logic                  m_tvalid,
	input  wire                   m_tready,
	output logic [OUT_W-1:0]      m_tdata,
	output logic                  space
);
	import bpc_pkg::*;

	logic             valid_q;
	logic [OUT_W-1:0] data_q;
	logic [OUT_W-1:0] packed_res;

	// Fields from bit 0 up: short pulses, long pulses, settled levels.
	always_comb begin
		packed_res = '0;
		for (int b = 0; b < BUTTONS; b++) begin
			packed_res[b]             = res[b].short_pulse;
			packed_res[BUTTONS + b]   = res[b].long_pulse;
			packed_res[2*BUTTONS + b] = res[b].level;
		end
	end

	assign space    = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= packed_res;
		end
	end

endmodule

`default_nettype wire
